[hdl/tea_pkg.sv]
// shared types, constants and schedule helpers for the tea block cipher
package tea_pkg;

    localparam int unsigned ROUNDS    = 32;
    localparam int unsigned STAGES    = 2 * ROUNDS;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_IDX_W = 4;

    localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_KEY_WORD_0 = 4'd0;
    localparam t_cfg_idx CFG_KEY_WORD_1 = 4'd1;
    localparam t_cfg_idx CFG_KEY_WORD_2 = 4'd2;
    localparam t_cfg_idx CFG_KEY_WORD_3 = 4'd3;

    typedef struct packed {
        t_word k0;
        t_word k1;
        t_word k2;
        t_word k3;
    } t_key;

    typedef struct packed {
        logic  kind;
        t_word v0;
        t_word v1;
    } t_blk;

    // per-stage schedule constants, evaluated at elaboration
    typedef struct packed {
        logic  odd;
        t_word sum_enc;
        t_word sum_dec;
    } t_sched;

    function automatic t_word round_sum(input int unsigned n);
        logic [63:0] p;
        p = 64'(DELTA) * 64'(n);
        return p[WORD_W-1:0];
    endfunction

    function automatic t_sched stage_sched(input int unsigned j);
        t_sched s;
        s.odd     = 1'(j % 2);
        s.sum_enc = round_sum(j / 2 + 1);
        s.sum_dec = round_sum(ROUNDS - j / 2);
        return s;
    endfunction

endpackage

[hdl/tea_in_if.sv]
// request channel: operation kind and the 64-bit input block
interface tea_in_if;
    logic         valid;
    logic         ready;
    logic         kind;
    logic [31:0]  word_first;
    logic [31:0]  word_second;

    modport source (output valid, output kind, output word_first, output word_second,
                    input ready);
    modport sink   (input valid, input kind, input word_first, input word_second,
                    output ready);
endinterface

[hdl/tea_out_if.sv]
// result channel: the processed 64-bit block
interface tea_out_if;
    logic         valid;
    logic         ready;
    logic [31:0]  result_first;
    logic [31:0]  result_second;

    modport source (output valid, output result_first, output result_second,
                    input ready);
    modport sink   (input valid, input result_first, input result_second,
                    output ready);
endinterface

[hdl/tea_key_regs.sv]
// key register file written through the configuration port
module tea_key_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  tea_pkg::t_cfg_idx i_cfg_index,
    input  tea_pkg::t_word    i_cfg_data,
    output tea_pkg::t_key     o_key
);

    tea_pkg::t_key r_key;
    tea_pkg::t_key n_key;

    always_comb begin
        n_key = r_key;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                tea_pkg::CFG_KEY_WORD_0: n_key.k0 = i_cfg_data;
                tea_pkg::CFG_KEY_WORD_1: n_key.k1 = i_cfg_data;
                tea_pkg::CFG_KEY_WORD_2: n_key.k2 = i_cfg_data;
                tea_pkg::CFG_KEY_WORD_3: n_key.k3 = i_cfg_data;
                default:                 n_key = r_key;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else begin
            r_key <= n_key;
        end
    end

    assign o_key = r_key;

endmodule

[hdl/tea_stage.sv]
// one half-round of tea, encrypt or decrypt, with its pipeline register
module tea_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tea_pkg::t_sched i_sched,
    input  tea_pkg::t_key   i_key,
    input  logic            i_valid,
    input  tea_pkg::t_blk   i_blk,
    output logic            o_ready,
    output logic            o_valid,
    output tea_pkg::t_blk   o_blk,
    input  logic            i_ready
);

    logic           r_valid;
    tea_pkg::t_blk  r_blk;
    tea_pkg::t_blk  n_blk;

    logic           upd_v1;
    tea_pkg::t_word x;
    tea_pkg::t_word ka;
    tea_pkg::t_word kb;
    tea_pkg::t_word sum;
    tea_pkg::t_word tgt;
    tea_pkg::t_word mix;
    tea_pkg::t_word res;

    // encrypt: even stage updates v0, odd updates v1; decrypt runs the other way
    always_comb begin
        upd_v1 = i_sched.odd ^ i_blk.kind;
        x      = upd_v1 ? i_blk.v0 : i_blk.v1;
        tgt    = upd_v1 ? i_blk.v1 : i_blk.v0;
        ka     = upd_v1 ? i_key.k2 : i_key.k0;
        kb     = upd_v1 ? i_key.k3 : i_key.k1;
        sum    = i_blk.kind ? i_sched.sum_dec : i_sched.sum_enc;
        mix    = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
        res    = i_blk.kind ? (tgt - mix) : (tgt + mix);
        n_blk  = i_blk;
        if (upd_v1) begin
            n_blk.v1 = res;
        end else begin
            n_blk.v0 = res;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_blk <= n_blk;
        end
    end

    assign o_valid = r_valid;
    assign o_blk   = r_blk;

endmodule

[hdl/tea_block_cipher_unit.sv]
// top level: tea block cipher pipeline with key registers
// Each request carries one 64-bit block and an encrypt/decrypt flag and leaves as one result.
// The 32 tea rounds are unrolled into 64 register stages, one half-round each, so a new
// block is taken every cycle while the result side accepts, and several blocks of either
// direction can be in flight at once. The last stage register is the output register; when
// the result side holds off, each stage keeps its block and the stall travels back through a
// ready chain, so the block stops taking requests only once every stage is full. The key is
// read by all stages at once and must only be written while no block is in flight.
module tea_block_cipher_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  tea_pkg::t_cfg_idx i_cfg_index,
    input  tea_pkg::t_word    i_cfg_data,
    tea_in_if.sink            i_req,
    tea_out_if.source         o_rsp
);

    tea_pkg::t_key key;

    logic          w_valid [0:tea_pkg::STAGES];
    logic          w_ready [0:tea_pkg::STAGES];
    tea_pkg::t_blk w_blk   [0:tea_pkg::STAGES];

    tea_key_regs u_key_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_key       (key)
    );

    assign w_valid[0]       = i_req.valid;
    assign w_blk[0].kind    = i_req.kind;
    assign w_blk[0].v0      = i_req.word_first;
    assign w_blk[0].v1      = i_req.word_second;
    assign i_req.ready      = w_ready[0];

    for (genvar j = 0; j < tea_pkg::STAGES; j++) begin : g_stage
        tea_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_sched (tea_pkg::stage_sched(j)),
            .i_key   (key),
            .i_valid (w_valid[j]),
            .i_blk   (w_blk[j]),
            .o_ready (w_ready[j]),
            .o_valid (w_valid[j+1]),
            .o_blk   (w_blk[j+1]),
            .i_ready (w_ready[j+1])
        );
    end

    assign o_rsp.valid                  = w_valid[tea_pkg::STAGES];
    assign o_rsp.result_first           = w_blk[tea_pkg::STAGES].v0;
    assign o_rsp.result_second          = w_blk[tea_pkg::STAGES].v1;
    assign w_ready[tea_pkg::STAGES]     = o_rsp.ready;

endmodule
